// File: rtl/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and helpers for the chunked HTTP body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Width of the chunk size accumulator and the data byte counter
    localparam int SIZE_BITS = 32;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    typedef enum logic [3:0] {
        PH_SIZE       = 4'd0,
        PH_SIZE_LINE  = 4'd1,
        PH_DATA       = 4'd2,
        PH_AFTER_DATA = 4'd3,
        PH_TR_BLANK   = 4'd4,
        PH_TR_CR      = 4'd5,
        PH_TR_LINE    = 4'd6,
        PH_DONE       = 4'd7,
        PH_ERROR      = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       chunk_end;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    // Decode one byte as a hex digit, either letter case
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - "0");
        end
        else if (c >= "a" && c <= "f")
        begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - "a" + 8'd10);
        end
        else if (c >= "A" && c <= "F")
        begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - "A" + 8'd10);
        end
        return h;
    endfunction

endpackage

// File: rtl/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes a chunk-encoded HTTP body one byte per item into payload bytes.
// ----------------------------------------------------------------------------
// Takes one raw body byte per cycle while in_stall is low and returns
// exactly one result item per byte: the byte with a payload mark when it is
// chunk data, a mark on the last data byte of each chunk, and a status of
// running, done or error. Each byte is captured in an input register,
// decoded combinationally against the phase, size and count registers, and
// the result is written to a three-entry output queue. Throughput is one
// byte per cycle while the input is not stalled, and input stalls only when
// the output queue and the input register together hold three items. Once
// done or in error, the block keeps reporting that status for every byte.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            payload_byte,
    output logic                  payload_valid,
    output logic                  chunk_end,
    output logic [1:0]            status
);

    localparam int SB    = hcbd_pkg::SIZE_BITS;
    localparam int QUEUE = 3;

    // Input register
    logic                 stage_valid_reg;
    logic [7:0]           stage_byte_reg;

    // Decoder state
    hcbd_pkg::phase_t     phase_reg, phase_next;
    logic [SB-1:0]        size_reg, size_next;
    logic                 seen_reg, seen_next;
    logic [SB-1:0]        remain_reg, remain_next;

    // Output queue
    hcbd_pkg::result_t    queue_reg [QUEUE];
    logic [1:0]           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]           count_reg, count_next;

    hcbd_pkg::result_t    res;
    hcbd_pkg::hex_t       hex;
    logic                 in_accept;
    logic                 push;
    logic                 pop;

    assign in_stall  = ({1'b0, count_reg} + {2'b00, stage_valid_reg}) >= 3'(QUEUE);
    assign in_accept = in_valid && !in_stall;
    assign push      = stage_valid_reg;
    assign out_valid = count_reg != 2'd0;
    assign pop       = out_valid && !out_stall;
    assign hex       = hcbd_pkg::hex_decode(stage_byte_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= in_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_byte_reg <= data_byte;
        end
    end

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        size_next   = size_reg;
        seen_next   = seen_reg;
        remain_next = remain_reg;
        unique case (phase_reg)
            hcbd_pkg::PH_SIZE:
            begin
                if (hex.is_hex)
                begin
                    if (size_reg[SB-1 -: 4] != 4'd0)
                    begin
                        phase_next = hcbd_pkg::PH_ERROR;
                    end
                    else
                    begin
                        size_next = {size_reg[SB-5:0], hex.value};
                        seen_next = 1'b1;
                    end
                end
                else if (!seen_reg)
                begin
                    phase_next = hcbd_pkg::PH_ERROR;
                end
                else if (stage_byte_reg == hcbd_pkg::CH_LF)
                begin
                    remain_next = size_reg;
                    phase_next  = (size_reg == '0) ? hcbd_pkg::PH_TR_BLANK
                                                   : hcbd_pkg::PH_DATA;
                end
                else
                begin
                    phase_next = hcbd_pkg::PH_SIZE_LINE;
                end
            end
            hcbd_pkg::PH_SIZE_LINE:
            begin
                if (stage_byte_reg == hcbd_pkg::CH_LF)
                begin
                    remain_next = size_reg;
                    phase_next  = (size_reg == '0) ? hcbd_pkg::PH_TR_BLANK
                                                   : hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                if (remain_reg != '0)
                begin
                    remain_next = remain_reg - SB'(1);
                end
                if (remain_reg <= SB'(1))
                begin
                    phase_next = hcbd_pkg::PH_AFTER_DATA;
                end
            end
            hcbd_pkg::PH_AFTER_DATA:
            begin
                if (stage_byte_reg == hcbd_pkg::CH_LF)
                begin
                    size_next  = '0;
                    seen_next  = 1'b0;
                    phase_next = hcbd_pkg::PH_SIZE;
                end
            end
            hcbd_pkg::PH_TR_BLANK, hcbd_pkg::PH_TR_CR, hcbd_pkg::PH_TR_LINE:
            begin
                if (stage_byte_reg == hcbd_pkg::CH_CR)
                begin
                    phase_next = (phase_reg == hcbd_pkg::PH_TR_BLANK)
                                 ? hcbd_pkg::PH_TR_CR : hcbd_pkg::PH_TR_LINE;
                end
                else if (stage_byte_reg == hcbd_pkg::CH_LF)
                begin
                    phase_next = (phase_reg == hcbd_pkg::PH_TR_LINE)
                                 ? hcbd_pkg::PH_TR_BLANK : hcbd_pkg::PH_DONE;
                end
                else
                begin
                    phase_next = hcbd_pkg::PH_TR_LINE;
                end
            end
            hcbd_pkg::PH_DONE:
            begin
                phase_next = hcbd_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = hcbd_pkg::PH_ERROR;
            end
        endcase
    end

    // Result for the byte in the input register
    always_comb
    begin
        res.payload_byte  = 8'd0;
        res.payload_valid = 1'b0;
        res.chunk_end     = 1'b0;
        res.status        = hcbd_pkg::ST_RUN;
        unique case (phase_reg)
            hcbd_pkg::PH_SIZE:
            begin
                if ((hex.is_hex && size_reg[SB-1 -: 4] != 4'd0) ||
                    (!hex.is_hex && !seen_reg))
                begin
                    res.status = hcbd_pkg::ST_ERR;
                end
            end
            hcbd_pkg::PH_SIZE_LINE, hcbd_pkg::PH_AFTER_DATA:
            begin
                res.status = hcbd_pkg::ST_RUN;
            end
            hcbd_pkg::PH_DATA:
            begin
                res.payload_byte  = stage_byte_reg;
                res.payload_valid = 1'b1;
                res.chunk_end     = remain_reg <= SB'(1);
            end
            hcbd_pkg::PH_TR_BLANK, hcbd_pkg::PH_TR_CR, hcbd_pkg::PH_TR_LINE:
            begin
                if (stage_byte_reg == hcbd_pkg::CH_LF &&
                    phase_reg != hcbd_pkg::PH_TR_LINE)
                begin
                    res.status = hcbd_pkg::ST_DONE;
                end
            end
            hcbd_pkg::PH_DONE:
            begin
                res.status = hcbd_pkg::ST_DONE;
            end
            default:
            begin
                res.status = hcbd_pkg::ST_ERR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hcbd_pkg::PH_SIZE;
            size_reg   <= '0;
            seen_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else if (stage_valid_reg)
        begin
            phase_reg  <= phase_next;
            size_reg   <= size_next;
            seen_reg   <= seen_next;
            remain_reg <= remain_next;
        end
    end

    // Output queue
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == 2'(QUEUE - 1)) ? 2'd0 : wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == 2'(QUEUE - 1)) ? 2'd0 : rd_ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= res;
        end
    end

    assign payload_byte  = queue_reg[rd_ptr_reg].payload_byte;
    assign payload_valid = queue_reg[rd_ptr_reg].payload_valid;
    assign chunk_end     = queue_reg[rd_ptr_reg].chunk_end;
    assign status        = queue_reg[rd_ptr_reg].status;

`ifndef NO_ASSERTIONS
    a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> stage_valid_reg)
        else $error("accepted item did not reach the input register");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'(QUEUE) |-> !push || pop)
        else $error("output queue overrun");

    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hcbd_pkg::PH_DATA |-> remain_reg != '0)
        else $error("data phase with no bytes remaining");

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hcbd_pkg::PH_DONE |=> phase_reg == hcbd_pkg::PH_DONE)
        else $error("left the done phase");

    a_end_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chunk_end |-> payload_valid && status == hcbd_pkg::ST_RUN)
        else $error("chunk end on a non-payload item");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chunked HTTP body decoder.
// ----------------------------------------------------------------------------
// Feeds one chunk-encoded body byte by byte: a few hand-built chunks, a long
// receiver hold-off, then many random chunks with random extensions and
// junk, and finally one randomly chosen ending (trailer, empty size or size
// overflow) followed by bytes the block must ignore. A predictor tracks the
// decoder's phase, size and count and queues the expected result of every
// byte; each result item leaving the block is checked against the oldest one.
// Both sides insert random gaps.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SB               = hcbd_pkg::SIZE_BITS;
    localparam int RANDOM_TARGET    = 1300;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int REPORT_LIMIT     = 10;

    typedef enum int
    {
        END_TRAILER,
        END_EMPTY_SIZE,
        END_OVERFLOW
    } body_end_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic [7:0] data_byte     = 8'h00;
    logic       out_stall     = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       chunk_end;
    logic [1:0] status;

    // Predictor state
    hcbd_pkg::phase_t      pred_phase;
    logic [SB-1:0]         pred_size;
    logic [SB-1:0]         pred_left;
    logic                  pred_seen;

    hcbd_pkg::result_t pending_decodes[$];
    int      bytes_sent   = 0;
    int      items_seen   = 0;
    int      failures     = 0;
    int      tx_quiet     = 0;
    int      rx_quiet     = 0;
    logic    start_hold   = 1'b0;
    logic    hold_done    = 1'b0;

    http_chunked_body_decoder u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .payload_byte  (payload_byte),
        .payload_valid (payload_valid),
        .chunk_end     (chunk_end),
        .status        (status)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void load_chunk_count();
        pred_left  = pred_size;
        pred_phase = (pred_size == '0) ? hcbd_pkg::PH_TR_BLANK : hcbd_pkg::PH_DATA;
    endfunction

    function automatic hcbd_pkg::result_t decode_byte(input logic [7:0] c);
        hcbd_pkg::result_t r;
        int      d;
        r        = '0;
        r.status = hcbd_pkg::ST_RUN;
        case (pred_phase)
            hcbd_pkg::PH_SIZE:
            begin
                d = digit_value(c);
                if (d >= 0)
                begin
                    if ((pred_size >> (SB - 4)) != '0)
                    begin
                        pred_phase = hcbd_pkg::PH_ERROR;
                        r.status   = hcbd_pkg::ST_ERR;
                    end
                    else
                    begin
                        pred_size = (pred_size << 4) | SB'(d);
                        pred_seen = 1'b1;
                    end
                end
                else if (!pred_seen)
                begin
                    pred_phase = hcbd_pkg::PH_ERROR;
                    r.status   = hcbd_pkg::ST_ERR;
                end
                else if (c == hcbd_pkg::CH_LF)
                    load_chunk_count();
                else
                    pred_phase = hcbd_pkg::PH_SIZE_LINE;
            end
            hcbd_pkg::PH_SIZE_LINE:
            begin
                if (c == hcbd_pkg::CH_LF)
                    load_chunk_count();
            end
            hcbd_pkg::PH_DATA:
            begin
                r.payload_byte  = c;
                r.payload_valid = 1'b1;
                if (pred_left != '0)
                    pred_left = pred_left - SB'(1);
                if (pred_left == '0)
                begin
                    r.chunk_end = 1'b1;
                    pred_phase  = hcbd_pkg::PH_AFTER_DATA;
                end
            end
            hcbd_pkg::PH_AFTER_DATA:
            begin
                if (c == hcbd_pkg::CH_LF)
                begin
                    pred_size  = '0;
                    pred_seen  = 1'b0;
                    pred_phase = hcbd_pkg::PH_SIZE;
                end
            end
            hcbd_pkg::PH_TR_BLANK, hcbd_pkg::PH_TR_CR, hcbd_pkg::PH_TR_LINE:
            begin
                if (c == hcbd_pkg::CH_CR)
                    pred_phase = (pred_phase == hcbd_pkg::PH_TR_BLANK)
                                 ? hcbd_pkg::PH_TR_CR : hcbd_pkg::PH_TR_LINE;
                else if (c == hcbd_pkg::CH_LF)
                begin
                    if (pred_phase == hcbd_pkg::PH_TR_LINE)
                        pred_phase = hcbd_pkg::PH_TR_BLANK;
                    else
                    begin
                        pred_phase = hcbd_pkg::PH_DONE;
                        r.status   = hcbd_pkg::ST_DONE;
                    end
                end
                else
                    pred_phase = hcbd_pkg::PH_TR_LINE;
            end
            hcbd_pkg::PH_DONE:
                r.status = hcbd_pkg::ST_DONE;
            default:
            begin
                pred_phase = hcbd_pkg::PH_ERROR;
                r.status   = hcbd_pkg::ST_ERR;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin : result_check
        hcbd_pkg::result_t got;
        hcbd_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.payload_byte  = payload_byte;
            got.payload_valid = payload_valid;
            got.chunk_end     = chunk_end;
            got.status        = hcbd_pkg::status_t'(status);
            if (pending_decodes.size() == 0)
                note_failure($sformatf("item %0d: result with nothing expected", items_seen));
            else
            begin
                want = pending_decodes.pop_front();
                if (got.payload_byte !== want.payload_byte
                    || got.payload_valid !== want.payload_valid
                    || got.chunk_end !== want.chunk_end
                    || got.status !== want.status)
                    note_failure($sformatf(
                        "item %0d: expected %02h/%0b/%0b/%0d got %02h/%0b/%0b/%0d",
                        items_seen, want.payload_byte, want.payload_valid,
                        want.chunk_end, want.status, got.payload_byte,
                        got.payload_valid, got.chunk_end, got.status));
            end
            items_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Gaps and the receiving side
    // ------------------------------------------------------------------
    task automatic pick_gap(inout int quiet, output int gap);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet > 0)
        begin
            quiet--;
            gap = 0;
        end
        else if (roll < 2)
        begin
            quiet = $urandom_range(30, 120);
            gap   = 0;
        end
        else if (roll < 60)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else if (roll < 98)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 50);
    endtask

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (start_hold && !hold_done)
            begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
                pick_gap(rx_quiet, stall_left);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        pick_gap(tx_quiet, gap);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        pending_decodes.push_back(decode_byte(b));
        bytes_sent++;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(hcbd_pkg::CH_CR);
        send_byte(hcbd_pkg::CH_LF);
    endtask

    // Random byte other than LF, optionally also excluding hex digits
    function automatic logic [7:0] random_byte(input bit allow_hex);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == hcbd_pkg::CH_LF || (!allow_hex && digit_value(b) >= 0));
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input int d);
        if (d < 10)
            return 8'("0" + d);
        return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
    endfunction

    task automatic send_size(input int unsigned value, input int zeros);
        logic [7:0]  digits[$];
        int unsigned v;
        v = value;
        repeat (zeros) send_byte("0");
        do
        begin
            digits.push_front(hex_char(v % 16));
            v = v / 16;
        end
        while (v != 0);
        foreach (digits[i])
            send_byte(digits[i]);
    endtask

    // Close the size line: bare LF, CR LF, or an extension up to LF
    task automatic send_size_line_end();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4)
            send_crlf();
        else if (roll < 7)
            send_byte(hcbd_pkg::CH_LF);
        else
        begin
            send_byte(roll == 7 ? 8'(";") : random_byte(1'b0));
            repeat ($urandom_range(0, 6)) send_byte(random_byte(1'b1));
            send_byte(hcbd_pkg::CH_LF);
        end
    endtask

    task automatic send_chunk(input int unsigned size);
        int roll;
        send_size(size, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0);
        send_size_line_end();
        repeat (size) send_byte(8'($urandom_range(0, 255)));
        roll = $urandom_range(0, 9);
        if (roll < 6)
            send_crlf();
        else if (roll < 8)
            send_byte(hcbd_pkg::CH_LF);
        else
        begin
            repeat ($urandom_range(1, 4)) send_byte(random_byte(1'b1));
            send_byte(hcbd_pkg::CH_LF);
        end
    endtask

    function automatic int unsigned random_chunk_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            return $urandom_range(1, 16);
        if (roll < 97)
            return $urandom_range(17, 64);
        return $urandom_range(200, 255);
    endfunction

    task automatic send_trailer_line();
        repeat ($urandom_range(1, 12)) send_byte(random_byte(1'b1));
        if ($urandom_range(0, 1))
            send_crlf();
        else
            send_byte(hcbd_pkg::CH_LF);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_bare_lf();
        send_text("1");
        send_byte(hcbd_pkg::CH_LF);
        send_byte(8'h00);
        send_byte(hcbd_pkg::CH_LF);
    endtask

    task automatic test_extension();
        send_text("02;x");
        send_crlf();
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_crlf();
    endtask

    task automatic test_after_data_junk();
        send_text("1");
        send_crlf();
        send_byte(8'h55);
        send_text("zz");
        send_byte(hcbd_pkg::CH_LF);
    endtask

    // Hold the receiver off long enough for the block to stall its input
    task automatic test_backpressure();
        start_hold = 1'b1;
        repeat (4) send_chunk($urandom_range(20, 40));
    endtask

    task automatic test_random_chunks();
        while (bytes_sent < RANDOM_TARGET)
            send_chunk(random_chunk_size());
    endtask

    task automatic test_body_end();
        body_end_t kind;
        kind = body_end_t'($urandom_range(0, 2));
        case (kind)
            END_TRAILER:
            begin
                send_size(0, $urandom_range(0, 2));
                send_size_line_end();
                repeat ($urandom_range(0, 2)) send_trailer_line();
                if ($urandom_range(0, 1))
                    send_crlf();
                else
                    send_byte(hcbd_pkg::CH_LF);
            end
            END_EMPTY_SIZE:
            begin
                case ($urandom_range(0, 2))
                    0:       send_byte(hcbd_pkg::CH_LF);
                    1:       send_byte(hcbd_pkg::CH_CR);
                    default: send_byte(random_byte(1'b0));
                endcase
            end
            END_OVERFLOW:
            begin
                // Eight digits with a nonzero top nibble, then one digit too many
                repeat ($urandom_range(0, 3)) send_byte("0");
                send_byte($urandom_range(0, 1) ? hex_char(15)
                                               : hex_char($urandom_range(1, 15)));
                repeat (7) send_byte(hex_char($urandom_range(0, 15)));
                send_byte(hex_char($urandom_range(0, 15)));
            end
            default: ;
        endcase
    endtask

    task automatic test_after_end();
        repeat (24) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin : main
        int guard;
        pred_phase = hcbd_pkg::PH_SIZE;
        pred_size  = '0;
        pred_left  = '0;
        pred_seen  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_bare_lf();
        test_extension();
        test_after_data_junk();
        test_backpressure();
        test_random_chunks();
        test_body_end();
        test_after_end();

        @(negedge clk);
        in_valid <= 1'b0;

        guard = 0;
        while (pending_decodes.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (pending_decodes.size() != 0)
            note_failure($sformatf("%0d expected items never arrived", pending_decodes.size()));

        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
